// ===== hdl/dap_pkg.sv =====
// ----------------------------------------------------------------------------
// dap_pkg
// Shared types, constants and helper functions for the decimal amount parser.
// ----------------------------------------------------------------------------
package dap_pkg;

  localparam int unsigned FRAC_DIGITS_DEF = 8;
  localparam int unsigned AMOUNT_W        = 52;

  localparam logic [63:0] MAX_WHOLE = 64'd21000000;
  localparam logic [63:0] WHOLE_CAP = 64'd1000000000000000000;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK,
    ST_EMPTY,
    ST_INVALID,
    ST_TOO_LARGE,
    ST_TOO_MANY_DEC,
    ST_OVER_MAX
  } status_t;

  // Control flags of the string being parsed. err holds the first error,
  // ST_OK while there is none.
  typedef struct packed {
    logic    at_start;
    logic    body_seen;
    logic    negative;
    logic    in_fraction;
    status_t err;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    at_start:    1'b1,
    body_seen:   1'b0,
    negative:    1'b0,
    in_fraction: 1'b0,
    err:         ST_OK
  };

  // Ten to the power n, saturating the exponent at 19 like a 64-bit table.
  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned k = 0; k < 19; k++) begin
      if (k < n) begin
        p = p * 64'd10;
      end
    end
    return p;
  endfunction

  // Largest whole accumulator value that is still accepted while digits
  // arrive; capped so the accumulator stays within 64 bits.
  function automatic logic [63:0] whole_limit(input int unsigned fd);
    logic [63:0] scale;
    scale = pow10(fd);
    if (scale > (WHOLE_CAP - 64'd1) / MAX_WHOLE) begin
      return WHOLE_CAP;
    end
    return MAX_WHOLE * scale + 64'd1;
  endfunction

endpackage

// ===== hdl/dap_char.sv =====
// ----------------------------------------------------------------------------
// dap_char
// Next-state logic for one character: sign, point, digit accumulation and
// first-error capture.
// ----------------------------------------------------------------------------
module dap_char import dap_pkg::*; #(
  parameter int unsigned FRAC_DIGITS = FRAC_DIGITS_DEF,
  parameter int unsigned WHOLE_W     = 55,
  parameter int unsigned FRAC_W      = 27,
  parameter int unsigned CNT_W       = 4
) (
  input  logic [7:0]         ch,
  input  logic               has_char,
  input  flags_t             flags,
  input  logic [WHOLE_W-1:0] whole,
  input  logic [FRAC_W-1:0]  frac,
  input  logic [CNT_W-1:0]   count,
  output flags_t             flags_next,
  output logic [WHOLE_W-1:0] whole_next,
  output logic [FRAC_W-1:0]  frac_next,
  output logic [CNT_W-1:0]   count_next
);

  localparam logic [63:0] WHOLE_LIMIT = whole_limit(FRAC_DIGITS);
  localparam int unsigned IDX_W = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;

  // Weight of each fraction position, most significant first.
  logic [FRAC_W-1:0] place [FRAC_DIGITS];

  for (genvar i = 0; i < FRAC_DIGITS; i++) begin : g_place
    assign place[i] = FRAC_W'(pow10(FRAC_DIGITS - 1 - i));
  end

  logic               is_digit;
  logic [3:0]         digit;
  logic [WHOLE_W-1:0] whole_x10;
  logic [WHOLE_W-1:0] whole_sum;
  logic [FRAC_W-1:0]  frac_add;

  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit     = ch[3:0];
  assign whole_x10 = (whole << 3) + (whole << 1);
  assign whole_sum = whole_x10 + WHOLE_W'(digit);
  assign frac_add  = place[count[IDX_W-1:0]] * FRAC_W'(digit);

  always_comb begin
    flags_next = flags;
    whole_next = whole;
    frac_next  = frac;
    count_next = count;
    if (has_char && (flags.err == ST_OK)) begin
      if (flags.at_start && ((ch == CH_MINUS) || (ch == CH_PLUS))) begin
        flags_next.at_start = 1'b0;
        flags_next.negative = (ch == CH_MINUS);
      end else begin
        flags_next.at_start  = 1'b0;
        flags_next.body_seen = 1'b1;
        if (ch == CH_POINT) begin
          if (flags.in_fraction) begin
            flags_next.err = ST_INVALID;
          end
          flags_next.in_fraction = 1'b1;
        end else if (!is_digit) begin
          flags_next.err = ST_INVALID;
        end else if (!flags.in_fraction) begin
          whole_next = whole_sum;
          if (whole_sum > WHOLE_W'(WHOLE_LIMIT)) begin
            flags_next.err = ST_TOO_LARGE;
          end
        end else if (count >= CNT_W'(FRAC_DIGITS)) begin
          flags_next.err = ST_TOO_MANY_DEC;
        end else begin
          // The fraction is kept already scaled to the full digit count.
          frac_next  = frac + frac_add;
          count_next = count + CNT_W'(1);
        end
      end
    end
  end

endmodule

// ===== hdl/dap_scale.sv =====
// ----------------------------------------------------------------------------
// dap_scale
// Final status decision and conversion of whole and fraction parts into a
// signed base-unit amount.
// ----------------------------------------------------------------------------
module dap_scale import dap_pkg::*; #(
  parameter int unsigned FRAC_DIGITS = FRAC_DIGITS_DEF,
  parameter int unsigned WHOLE_W     = 55,
  parameter int unsigned FRAC_W      = 27
) (
  input  flags_t                       flags,
  input  logic [WHOLE_W-1:0]           whole,
  input  logic [FRAC_W-1:0]            frac,
  output logic signed [AMOUNT_W-1:0]   amount,
  output status_t                      status
);

  localparam int unsigned MW = $clog2(MAX_WHOLE + 64'd1);
  localparam logic [AMOUNT_W-1:0] UNIT = AMOUNT_W'(pow10(FRAC_DIGITS));

  logic              over;
  logic [AMOUNT_W-1:0] mag;

  assign over = (whole > WHOLE_W'(MAX_WHOLE)) ||
                ((whole == WHOLE_W'(MAX_WHOLE)) && (frac != '0));

  // Only used when the whole part is within the supply limit.
  assign mag = AMOUNT_W'(whole[MW-1:0]) * UNIT + AMOUNT_W'(frac);

  always_comb begin
    amount = '0;
    if (flags.at_start) begin
      status = ST_EMPTY;
    end else if (flags.err != ST_OK) begin
      status = flags.err;
    end else if (!flags.body_seen) begin
      status = ST_INVALID;
    end else if (over) begin
      status = ST_OVER_MAX;
    end else begin
      status = ST_OK;
      amount = flags.negative ? signed'(-mag) : signed'(mag);
    end
  end

endmodule

// ===== hdl/decimal_amount_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_amount_parser
// Parses a decimal amount string, one character per transfer, into a signed
// fixed-point value in base units with a status code.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------
//  char     | char_valid / char_ready    | ch[7:0], has_char, last
//  result   | result_valid / result_ready| amount[51:0] signed, status[2:0]
//
// One character is taken every cycle while char_ready is high. The item marked
// last yields one result through a snapshot register, then the scaling multiply
// by 10^FRAC_DIGITS into the result register. Reset returns the parser to the
// start of a string and empties both registers. A stalled result holds the
// snapshot stage; char_ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module decimal_amount_parser import dap_pkg::*; #(
  parameter int unsigned FRAC_DIGITS = FRAC_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       char_valid,
  output logic                       char_ready,
  input  logic [7:0]                 ch,
  input  logic                       has_char,
  input  logic                       last,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic signed [AMOUNT_W-1:0] amount,
  output logic [2:0]                 status
);

  localparam logic [63:0] WHOLE_LIMIT = whole_limit(FRAC_DIGITS);
  localparam int unsigned WHOLE_W = $clog2(WHOLE_LIMIT * 64'd10 + 64'd10);
  localparam int unsigned FRAC_W  = $clog2(pow10(FRAC_DIGITS));
  localparam int unsigned CNT_W   = $clog2(FRAC_DIGITS + 1);

  // Parse state.
  flags_t             flags, flags_next;
  logic [WHOLE_W-1:0] whole_acc, whole_acc_next;
  logic [FRAC_W-1:0]  frac_acc, frac_acc_next;
  logic [CNT_W-1:0]   frac_count, frac_count_next;

  // Snapshot stage.
  logic               snap_valid;
  flags_t             snap_flags;
  logic [WHOLE_W-1:0] snap_whole;
  logic [FRAC_W-1:0]  snap_frac;

  logic                       out_take, snap_take, accept;
  logic signed [AMOUNT_W-1:0] amount_next;
  status_t                    status_next;

  assign out_take   = !result_valid || result_ready;
  assign snap_take  = !snap_valid || out_take;
  assign char_ready = snap_take;
  assign accept     = char_valid && char_ready;

  dap_char #(
    .FRAC_DIGITS(FRAC_DIGITS),
    .WHOLE_W    (WHOLE_W),
    .FRAC_W     (FRAC_W),
    .CNT_W      (CNT_W)
  ) u_char (
    .ch        (ch),
    .has_char  (has_char),
    .flags     (flags),
    .whole     (whole_acc),
    .frac      (frac_acc),
    .count     (frac_count),
    .flags_next(flags_next),
    .whole_next(whole_acc_next),
    .frac_next (frac_acc_next),
    .count_next(frac_count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= FLAGS_RESET;
      whole_acc  <= '0;
      frac_acc   <= '0;
      frac_count <= '0;
    end else if (accept) begin
      if (last) begin
        flags      <= FLAGS_RESET;
        whole_acc  <= '0;
        frac_acc   <= '0;
        frac_count <= '0;
      end else begin
        flags      <= flags_next;
        whole_acc  <= whole_acc_next;
        frac_acc   <= frac_acc_next;
        frac_count <= frac_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_take) begin
      snap_valid <= accept && last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      snap_flags <= flags_next;
      snap_whole <= whole_acc_next;
      snap_frac  <= frac_acc_next;
    end
  end

  dap_scale #(
    .FRAC_DIGITS(FRAC_DIGITS),
    .WHOLE_W    (WHOLE_W),
    .FRAC_W     (FRAC_W)
  ) u_scale (
    .flags (snap_flags),
    .whole (snap_whole),
    .frac  (snap_frac),
    .amount(amount_next),
    .status(status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_take) begin
      result_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && snap_valid) begin
      amount <= amount_next;
      status <= status_next;
    end
  end

  // Any non-ok result carries a zero amount.
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != ST_OK)) |-> (amount == '0))
    else $error("non-zero amount with error status");

  // Status codes beyond the over-max code are never produced.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status <= ST_OVER_MAX))
    else $error("status code out of range");

  // The transfer that ends a string leaves the parser at the start state.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (flags == FLAGS_RESET) && (whole_acc == '0))
    else $error("parser not restarted after last character");

  // The first error sticks until the string ends.
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    ((flags.err != ST_OK) && !(accept && last)) |=> (flags.err == $past(flags.err)))
    else $error("captured error changed before end of string");

endmodule
